// File: sv/full_linear_convolution_fir_unit_assert.svh
// Assertion macros used by the checker file of the convolution unit.
`ifndef FULL_LINEAR_CONVOLUTION_FIR_UNIT_ASSERT_SVH
`define FULL_LINEAR_CONVOLUTION_FIR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FLCFIR_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FLCFIR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// File: sv/flcfir_pkg.sv
// Types and constants shared by the convolution unit files.
package flcfir_pkg;

  localparam int VALUE_W          = 16;
  localparam int PROD_W           = 2 * VALUE_W;
  localparam int ACC_W            = 36;
  localparam int TAP_IDX_W        = 5;
  localparam int TAP_CNT_W        = 6;
  localparam int MAX_TAPS_DEFAULT = 32;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 6'd29;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic clear;   // zero the accumulator, drop any pending product
    logic step;    // take a new product this cycle
    logic tap_on;  // the product belongs to a tap in use
  } mac_ctrl_t;

endpackage

// File: sv/flcfir_if.sv
// Valid/ready channel interfaces for the convolution unit.
interface flcfir_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [flcfir_pkg::TAP_IDX_W-1:0]    tap_index;
  logic signed [flcfir_pkg::VALUE_W-1:0] value;
  logic                                last_sample;

  modport source (output valid, output kind, output tap_index, output value,
                  output last_sample, input ready);
  modport sink   (input valid, input kind, input tap_index, input value,
                  input last_sample, output ready);
endinterface

interface flcfir_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [flcfir_pkg::ACC_W-1:0] output_value;
  logic                                last_output;

  modport source (output valid, output output_value, output last_output,
                  input ready);
  modport sink   (input valid, input output_value, input last_output,
                  output ready);
endinterface

// File: sv/flcfir_mac.sv
// Shared multiply-accumulate unit: registered product, then 36-bit sum.
module flcfir_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  flcfir_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [flcfir_pkg::VALUE_W-1:0]  coef,
  input  logic signed [flcfir_pkg::VALUE_W-1:0]  sample,
  output logic signed [flcfir_pkg::ACC_W-1:0]    acc
);

  logic signed [flcfir_pkg::PROD_W-1:0] prod;
  logic                                 prod_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_use <= 1'b0;
    end else if (ctrl.clear) begin
      prod_use <= 1'b0;
    end else begin
      prod_use <= ctrl.step && ctrl.tap_on;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_use) begin
      // wraps modulo 2^36
      acc <= acc + flcfir_pkg::ACC_W'(prod);
    end
    if (ctrl.step) begin
      prod <= coef * sample;
    end
  end

endmodule

// File: sv/full_linear_convolution_fir_unit.sv
// Full linear convolution FIR: one shared multiply-accumulate over a rotating tap line.
//
// Channels: in_ch carries items; kind selects a coefficient write (tap_index,
// value) or a signal sample (value, last_sample). A coefficient write gives no
// result. out_ch carries Q5.30 results and last_output. cfg_we/cfg_wdata write
// tap_count; the user must write it only while the block is idle, which the
// block itself does not enforce. Timing: a sample is taken when in_ch.ready is
// high; ready then drops while the multiply-accumulate walks all MAX_TAPS
// positions of the delay line and coefficient store, one tap per cycle, then a
// drain state. The result is registered on out_ch once the output register is
// free, and ready returns in that same cycle unless tail results follow. A
// sample marked last is followed by tap_count-1 tail results (tap_count clamped
// to 1..MAX_TAPS), the last one marked; the delay line is then zeroed.
// Reset (synchronous, rst high) zeroes delay line and coefficients, sets
// tap_count to 29 and empties the output register.
// A stalled receiver holds the output register; the next result waits in
// the accumulator and the block does not advance until the beat is taken.
module full_linear_convolution_fir_unit #(
  parameter int MAX_TAPS = flcfir_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [flcfir_pkg::TAP_CNT_W-1:0]   cfg_wdata,
  flcfir_in_if.sink                          in_ch,
  flcfir_out_if.source                       out_ch
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DRAIN, ST_EMIT} state_t;

  state_t                                state;
  logic [flcfir_pkg::TAP_CNT_W-1:0]      tap_count;
  logic [AW-1:0]                         cnt;
  logic [CW-1:0]                         n_taps;
  logic [CW-1:0]                         n_calc;
  logic [CW-1:0]                         tail_left;
  logic                                  is_last;
  logic                                  out_valid;
  logic signed [flcfir_pkg::ACC_W-1:0]   out_value;
  logic                                  out_last;

  logic signed [flcfir_pkg::VALUE_W-1:0] dly  [MAX_TAPS];
  logic signed [flcfir_pkg::VALUE_W-1:0] coef [MAX_TAPS];

  logic                                  in_acc;
  logic                                  sample_acc;
  logic                                  coef_acc;
  logic                                  emit_go;
  logic                                  tail_go;
  logic                                  done_blk;
  flcfir_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [flcfir_pkg::ACC_W-1:0]   acc;

  assign in_ch.ready         = (state == ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.output_value = out_value;
  assign out_ch.last_output  = out_last;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign sample_acc = in_acc && (in_ch.kind == flcfir_pkg::KIND_SAMPLE);
  assign coef_acc   = in_acc && (in_ch.kind == flcfir_pkg::KIND_COEF) &&
                      (32'(in_ch.tap_index) < MAX_TAPS);
  assign emit_go    = (state == ST_EMIT) && (!out_valid || out_ch.ready);
  assign tail_go    = emit_go && is_last && (tail_left != '0);
  assign done_blk   = emit_go && is_last && (tail_left == '0);

  // Clamp the tap count to 1..MAX_TAPS.
  always_comb begin
    if (tap_count == '0) begin
      n_calc = CW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      n_calc = CW'(MAX_TAPS);
    end else begin
      n_calc = CW'(tap_count);
    end
  end

  always_comb begin
    mac_ctrl.clear  = sample_acc || tail_go;
    mac_ctrl.step   = (state == ST_MAC);
    mac_ctrl.tap_on = (CW'(cnt) < n_taps);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= flcfir_pkg::TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  // Delay line: shift on a new sample or tail zero, rotate one place per MAC cycle.
  always_ff @(posedge clk) begin
    if (rst || done_blk) begin
      for (int k = 0; k < MAX_TAPS; k++) dly[k] <= '0;
    end else if (sample_acc || tail_go) begin
      for (int k = 1; k < MAX_TAPS; k++) dly[k] <= dly[k-1];
      dly[0] <= sample_acc ? in_ch.value : '0;
    end else if (state == ST_MAC) begin
      for (int k = 0; k < MAX_TAPS - 1; k++) dly[k] <= dly[k+1];
      dly[MAX_TAPS-1] <= dly[0];
    end
  end

  // Coefficients rotate in step with the delay line and come back aligned.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) coef[k] <= '0;
    end else if (coef_acc) begin
      coef[AW'(in_ch.tap_index)] <= in_ch.value;
    end else if (state == ST_MAC) begin
      for (int k = 0; k < MAX_TAPS - 1; k++) coef[k] <= coef[k+1];
      coef[MAX_TAPS-1] <= coef[0];
    end
  end

  flcfir_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (coef[0]),
    .sample (dly[0]),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      is_last   <= 1'b0;
      tail_left <= '0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
        out_value <= acc;
        out_last  <= is_last && (tail_left == '0);
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_acc) begin
            n_taps    <= n_calc;
            is_last   <= in_ch.last_sample;
            tail_left <= n_calc - CW'(1);
            cnt       <= '0;
            state     <= ST_MAC;
          end
        end
        ST_MAC: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(MAX_TAPS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (tail_go) begin
            tail_left <= tail_left - CW'(1);
            cnt       <= '0;
            state     <= ST_MAC;
          end else if (emit_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/flcfir_checker.sv
// Port-level checker for the convolution unit, bound to the top level.
`include "full_linear_convolution_fir_unit_assert.svh"

module flcfir_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_kind,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [flcfir_pkg::ACC_W-1:0] out_value,
  input logic                                out_last
);

  // Hold a stalled result beat.
  `FLCFIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FLCFIR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(out_value) && $stable(out_last))
  // A sample beat starts a busy stretch.
  `FLCFIR_ASSERT_NEXT(a_busy_after_sample,
    in_valid && in_ready && (in_kind == flcfir_pkg::KIND_SAMPLE), !in_ready)
  // A new result only comes out of a busy stretch.
  `FLCFIR_ASSERT_IMPL(a_result_from_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind full_linear_convolution_fir_unit flcfir_checker u_flcfir_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.output_value),
  .out_last  (out_ch.last_output)
);
